### hw/rtl/tsr_pkg.sv
// Package for the triangle span rasterizer: types and fixed constants.
// No dependencies.
`timescale 1ns / 1ps
package tsr_pkg;
    localparam int unsigned CoordW = 12;
    localparam int unsigned ColorW = 16;
    localparam int unsigned RowW   = 8;

    typedef enum logic [0:0] {
        K_LOAD = 1'b0,
        K_TICK = 1'b1
    } t_kind;

    typedef struct packed {
        logic              kind;
        logic signed [CoordW-1:0] vx0;
        logic signed [CoordW-1:0] vy0;
        logic signed [CoordW-1:0] vx1;
        logic signed [CoordW-1:0] vy1;
        logic signed [CoordW-1:0] vx2;
        logic signed [CoordW-1:0] vy2;
        logic [ColorW-1:0] fill_color;
    } t_in_word;

    typedef struct packed {
        logic              has_span;
        logic signed [CoordW-1:0] span_left;
        logic signed [CoordW-1:0] span_right;
        logic [RowW-1:0]   row;
        logic [ColorW-1:0] span_color;
        logic              last_span;
    } t_out_word;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT,
        S_EDGE_INIT,
        S_WALK,
        S_EDGE_DONE,
        S_TICK_RD,
        S_TICK_OUT
    } t_state;

    // Bus from the sequencer to the bound memory.
    typedef struct packed {
        logic        we;
        logic        side;
        logic [9:0]  waddr;
        logic signed [CoordW-1:0] wdata;
        logic [9:0]  raddr;
    } t_mem_req;
endpackage

### hw/rtl/tsr_if.sv
// Valid/ready channel interface carrying one word of a given type.
// No dependencies; the word type T is a parameter.
`timescale 1ns / 1ps
interface tsr_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/tsr_bound_mem.sv
// Edge bound memories for the short side and the long side, with registered reads.
// Depends on tsr_pkg.
`timescale 1ns / 1ps
module tsr_bound_mem #(
    parameter int unsigned Depth = 240
) (
    input  logic i_clk,
    input  tsr_pkg::t_mem_req i_req,
    output logic signed [tsr_pkg::CoordW-1:0] o_short,
    output logic signed [tsr_pkg::CoordW-1:0] o_long
);
    import tsr_pkg::*;
    localparam int unsigned AW = $clog2(Depth);
    logic signed [CoordW-1:0] r_mem_s [Depth];
    logic signed [CoordW-1:0] r_mem_l [Depth];

    always_ff @(posedge i_clk) begin
        if (i_req.we && !i_req.side) r_mem_s[i_req.waddr[AW-1:0]] <= i_req.wdata;
        if (i_req.we && i_req.side) r_mem_l[i_req.waddr[AW-1:0]] <= i_req.wdata;
        o_short <= r_mem_s[i_req.raddr[AW-1:0]];
        o_long  <= r_mem_l[i_req.raddr[AW-1:0]];
    end
endmodule

### hw/rtl/triangle_span_rasterizer.sv
// Top level of the triangle span rasterizer: sequencer, edge walker, output stage.
// Depends on tsr_pkg, tsr_if and tsr_bound_mem.
//
// Use: the input channel carries load and tick words; the output channel carries
// one span word per tick and nothing per load. A load sorts the vertices and walks
// the edges with one Bresenham step per cycle, writing the x where each edge
// leaves a row into the bound memory. It sorts in S_SORT, then for each edge walked
// passes S_EDGE_INIT, S_WALK and S_EDGE_DONE, where an edge takes as many steps as the
// larger of its dx and dy; the next word is taken after the last edge is done.
// A tick reads both bounds at the current row from the memory port; its span word
// is written to the output register in S_TICK_OUT, after S_TICK_RD, and the next
// word can be taken once the block is back in S_IDLE. The block accepts a new word
// while that span word waits to be taken, and it stalls at a tick only when the
// output register is still full. Reset clears the row range and the side choice;
// the bound memory holds no reset value and is only read at rows written by the
// current triangle.
`timescale 1ns / 1ps
module triangle_span_rasterizer #(
    parameter int unsigned SCREEN_ROWS = 240
) (
    input logic i_clk,
    input logic i_rst_n,
    tsr_if.sink   i_in,
    tsr_if.source o_out
);
    import tsr_pkg::*;
    localparam int unsigned CW = CoordW + 2;
    localparam int unsigned RW = $clog2(SCREEN_ROWS + 1);

    t_state r_state, n_state;
    logic signed [CW-1:0] r_x [3];
    logic signed [CW-1:0] r_y [3];
    logic signed [CW-1:0] r_wx, r_wy, r_tx, r_ty, r_dx, r_dy, r_sx, r_sy;
    logic signed [CW+1:0] r_err;
    logic [1:0]  r_edge;
    logic signed [CW-1:0] r_smid, r_lmid;
    logic [RW-1:0] r_cur, r_end;
    logic r_left_short;
    logic [ColorW-1:0] r_color;
    logic r_ovalid;
    t_out_word r_oword;
    t_mem_req  mreq;
    logic signed [CoordW-1:0] rd_s, rd_l;
    t_in_word  iw;

    assign iw = i_in.data;

    tsr_bound_mem #(.Depth(SCREEN_ROWS)) u_mem (
        .i_clk(i_clk), .i_req(mreq), .o_short(rd_s), .o_long(rd_l));

    // Walker combinational step.
    logic signed [CW+2:0] e2;
    logic step_x, step_y, at_end, rec;
    logic signed [CW-1:0] nx;
    assign e2 = {r_err, 1'b0};
    assign at_end = (r_wx == r_tx) && (r_wy == r_ty);
    assign step_x = e2 >= (CW+3)'(r_dy);
    assign step_y = e2 <= (CW+3)'(r_dx);
    assign nx = step_x ? r_wx + r_sx : r_wx;
    assign rec = at_end || step_y;

    always_comb begin
        mreq.we    = (r_state == S_WALK) && rec && (r_wy >= 0)
                     && (r_wy < $signed(CW'(SCREEN_ROWS - 1)));
        mreq.side  = (r_edge == 2'd2);
        mreq.waddr = 10'(r_wy);
        mreq.wdata = CoordW'(at_end ? r_wx : nx);
        mreq.raddr = 10'(r_cur);
    end

    logic can_tick;
    assign can_tick = !r_ovalid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && (iw.kind == K_LOAD || can_tick);
    assign o_out.valid = r_ovalid;
    assign o_out.data = r_oword;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_in.valid && i_in.ready)
                n_state = (iw.kind == K_LOAD) ? S_SORT : S_TICK_RD;
            S_SORT: n_state = S_EDGE_INIT;
            S_EDGE_INIT: n_state = S_WALK;
            S_WALK: if (at_end) n_state = S_EDGE_DONE;
            S_EDGE_DONE: n_state = (r_edge == 2'd2) ? S_IDLE : S_EDGE_INIT;
            S_TICK_RD: n_state = S_TICK_OUT;
            S_TICK_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    logic signed [CW-1:0] ax, ay, bx, by;
    always_comb begin
        ax = r_x[0]; ay = r_y[0]; bx = r_x[1]; by = r_y[1];
        case (r_edge)
            2'd1: begin ax = r_x[1]; ay = r_y[1]; bx = r_x[2]; by = r_y[2]; end
            2'd2: begin bx = r_x[2]; by = r_y[2]; end
            default: ;
        endcase
    end

    logic is_last_t;
    logic signed [CW-1:0] lo, hi;
    assign lo = (r_y[0] < 0) ? '0 : r_y[0];
    assign hi = (r_y[2] >= $signed(CW'(SCREEN_ROWS))) ? CW'(SCREEN_ROWS - 1) : r_y[2];
    assign is_last_t = (r_cur + 1'b1 == r_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_cur <= '0;
            r_end <= '0;
            r_left_short <= 1'b0;
        end else begin
            if (r_ovalid && o_out.ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_in.valid && i_in.ready && iw.kind == K_LOAD) begin
                    r_x[0] <= CW'(iw.vx0); r_y[0] <= CW'(iw.vy0);
                    r_x[1] <= CW'(iw.vx1); r_y[1] <= CW'(iw.vy1);
                    r_x[2] <= CW'(iw.vx2); r_y[2] <= CW'(iw.vy2);
                    r_color <= iw.fill_color;
                    r_edge <= 2'd0;
                    r_smid <= '0; r_lmid <= '0;
                end
                S_SORT: begin
                    // Three-compare sorting network, done combinationally and registered in S_SORT.
                    logic signed [CW-1:0] tx, ty, mx, my, bxx, byy;
                    tx = r_x[0]; ty = r_y[0]; mx = r_x[1]; my = r_y[1];
                    bxx = r_x[2]; byy = r_y[2];
                    if (my < ty) begin {tx, ty, mx, my} = {mx, my, tx, ty}; end
                    if (byy < my) begin {bxx, byy, mx, my} = {mx, my, bxx, byy}; end
                    if (my < ty) begin {tx, ty, mx, my} = {mx, my, tx, ty}; end
                    r_x[0] <= tx; r_y[0] <= ty; r_x[1] <= mx; r_y[1] <= my;
                    r_x[2] <= bxx; r_y[2] <= byy;
                    if (ty == my) r_edge <= 2'd1;
                end
                S_EDGE_INIT: begin
                    logic signed [CW-1:0] ddx, ddy;
                    ddx = (ax < bx) ? bx - ax : ax - bx;
                    ddy = (ay < by) ? ay - by : by - ay;
                    r_wx <= ax; r_wy <= ay; r_tx <= bx; r_ty <= by;
                    r_dx <= ddx; r_dy <= ddy;
                    r_sx <= (ax < bx) ? CW'(1) : -CW'(1);
                    r_sy <= (ay < by) ? CW'(1) : -CW'(1);
                    r_err <= (CW+2)'(ddx) + (CW+2)'(ddy);
                    if (r_edge == 2'd1 && r_y[1] == r_y[2]) r_edge <= 2'd2;
                end
                S_WALK: begin
                    if (rec && r_wy == r_y[1]) begin
                        if (r_edge == 2'd2) r_lmid <= at_end ? r_wx : nx;
                        else r_smid <= at_end ? r_wx : nx;
                    end
                    if (!at_end) begin
                        r_wx <= nx;
                        r_err <= r_err + (step_x ? (CW+2)'(r_dy) : '0)
                                 + (step_y ? (CW+2)'(r_dx) : '0);
                        if (step_y) r_wy <= r_wy + r_sy;
                    end
                end
                S_EDGE_DONE: begin
                    if (r_edge == 2'd2) begin
                        r_left_short <= r_smid < r_lmid;
                        if (lo < hi) begin
                            r_cur <= RW'(lo); r_end <= RW'(hi);
                        end else begin
                            r_cur <= '0; r_end <= '0;
                        end
                    end else if (r_edge == 2'd0 && r_y[1] == r_y[2]) begin
                        r_edge <= 2'd2;
                    end else begin
                        r_edge <= r_edge + 2'd1;
                    end
                end
                S_TICK_RD: ;
                S_TICK_OUT: begin
                    r_ovalid <= 1'b1;
                    if (r_cur < r_end) begin
                        r_oword.has_span   <= 1'b1;
                        r_oword.span_left  <= r_left_short ? rd_s : rd_l;
                        r_oword.span_right <= r_left_short ? rd_l : rd_s;
                        r_oword.row        <= RowW'(r_cur);
                        r_oword.span_color <= r_color;
                        r_oword.last_span  <= is_last_t;
                        r_cur <= r_cur + 1'b1;
                    end else begin
                        r_oword <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_out.ready) |-> (r_state != S_TICK_OUT))
        else $error("span word overwritten while stalled");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> (r_state == S_IDLE))
        else $error("word accepted while busy");
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur <= r_end) || (r_end == '0))
        else $error("row past end");
endmodule

### tb/sv/testbench.sv
// Testbench for triangle_span_rasterizer: loads triangles, requests spans and checks each
// span word against a behavioral scanline model kept in this file.
// Depends on tsr_pkg, tsr_if and the rasterizer RTL.
`timescale 1ns / 1ps
module testbench;
    import tsr_pkg::*;

    localparam int Rows = 240;
    localparam int CycleLimit = 4000000;

    logic i_clk;
    logic i_rst_n;

    tsr_if #(.T(t_in_word))  in_ch ();
    tsr_if #(.T(t_out_word)) out_ch ();

    triangle_span_rasterizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    int        bounds [2][Rows];
    bit        left_short;
    int        cur_row;
    int        last_row;
    logic [15:0] color_q;
    t_out_word span_queue [$];
    int        errors;
    int        sent;
    int        cycles;
    bit        no_idle;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    task automatic trace_edge(input int side, input int x1, input int y1, input int x2,
                              input int y2, input int midy, inout int cap);
        int x, y, dx, dy, sx, sy, err, e2;
        x = x1;
        y = y1;
        dx = (x1 < x2) ? x2 - x1 : x1 - x2;
        sx = (x1 < x2) ? 1 : -1;
        dy = -((y1 < y2) ? y2 - y1 : y1 - y2);
        sy = (y1 < y2) ? 1 : -1;
        err = dx + dy;
        forever begin
            if (x == x2 && y == y2) begin
                if (y >= 0 && y < Rows - 1) bounds[side][y] = x;
                if (y == midy) cap = x;
                break;
            end
            e2 = 2 * err;
            if (e2 >= dy) begin
                err += dy;
                x += sx;
            end
            if (e2 <= dx) begin
                if (y >= 0 && y < Rows - 1) bounds[side][y] = x;
                if (y == midy) cap = x;
                err += dx;
                y += sy;
            end
        end
    endtask

    task automatic rasterize_load(input t_in_word w);
        int vx [3];
        int vy [3];
        int t, m, b, tmp, short_mid, long_mid, lo, hi;
        vx[0] = int'(w.vx0); vy[0] = int'(w.vy0);
        vx[1] = int'(w.vx1); vy[1] = int'(w.vy1);
        vx[2] = int'(w.vx2); vy[2] = int'(w.vy2);
        t = 0; m = 1; b = 2;
        short_mid = 0;
        long_mid = 0;
        if (vy[m] < vy[t]) begin tmp = t; t = m; m = tmp; end
        if (vy[b] < vy[m]) begin tmp = b; b = m; m = tmp; end
        if (vy[m] < vy[t]) begin tmp = t; t = m; m = tmp; end
        if (vy[t] != vy[m]) trace_edge(0, vx[t], vy[t], vx[m], vy[m], vy[m], short_mid);
        if (vy[m] != vy[b]) trace_edge(0, vx[m], vy[m], vx[b], vy[b], vy[m], short_mid);
        trace_edge(1, vx[t], vy[t], vx[b], vy[b], vy[m], long_mid);
        left_short = short_mid < long_mid;
        color_q = w.fill_color;
        lo = (vy[t] < 0) ? 0 : vy[t];
        hi = (vy[b] >= Rows) ? Rows - 1 : vy[b];
        if (lo < hi) begin
            cur_row = lo;
            last_row = hi;
        end else begin
            cur_row = 0;
            last_row = 0;
        end
    endtask

    function automatic t_out_word next_span();
        t_out_word o;
        o = '0;
        if (cur_row < last_row) begin
            o.has_span   = 1'b1;
            o.span_left  = left_short ? bounds[0][cur_row] : bounds[1][cur_row];
            o.span_right = left_short ? bounds[1][cur_row] : bounds[0][cur_row];
            o.row        = cur_row[7:0];
            o.span_color = color_q;
            o.last_span  = (cur_row + 1 == last_row);
            cur_row++;
        end
        return o;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 14);
    endfunction

    task automatic send_word(input t_in_word w);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do @(posedge i_clk); while (!in_ch.ready);
        if (w.kind == K_LOAD) rasterize_load(w);
        else span_queue.push_back(next_span());
        sent++;
    endtask

    task automatic send_load(input int x0, input int y0, input int x1, input int y1,
                             input int x2, input int y2, input logic [15:0] c);
        t_in_word w;
        w.kind = K_LOAD;
        w.vx0 = x0[11:0]; w.vy0 = y0[11:0];
        w.vx1 = x1[11:0]; w.vy1 = y1[11:0];
        w.vx2 = x2[11:0]; w.vy2 = y2[11:0];
        w.fill_color = c;
        send_word(w);
    endtask

    task automatic send_ticks(input int n);
        t_in_word w;
        logic [95:0] rnd;
        repeat (n) begin
            rnd = {$urandom, $urandom, $urandom};
            w = rnd[$bits(t_in_word)-1:0];
            w.kind = K_TICK;
            send_word(w);
        end
    endtask

    initial begin : span_checker
        t_out_word got, want;
        int gap;
        out_ch.ready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready));
            got = out_ch.data;
            if (span_queue.size() == 0) begin
                $display("%0t: unexpected span word, expected none, actual %h", $time, got);
                errors++;
            end else begin
                want = span_queue.pop_front();
                if (got.has_span !== want.has_span) begin
                    $display("%0t: has_span expected %0d actual %0d",
                             $time, want.has_span, got.has_span);
                    errors++;
                end
                if (got.span_left !== want.span_left) begin
                    $display("%0t: span_left expected %0d actual %0d",
                             $time, want.span_left, got.span_left);
                    errors++;
                end
                if (got.span_right !== want.span_right) begin
                    $display("%0t: span_right expected %0d actual %0d",
                             $time, want.span_right, got.span_right);
                    errors++;
                end
                if (got.row !== want.row) begin
                    $display("%0t: row expected %0d actual %0d", $time, want.row, got.row);
                    errors++;
                end
                if (got.span_color !== want.span_color) begin
                    $display("%0t: span_color expected %h actual %h",
                             $time, want.span_color, got.span_color);
                    errors++;
                end
                if (got.last_span !== want.last_span) begin
                    $display("%0t: last_span expected %0d actual %0d",
                             $time, want.last_span, got.last_span);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        send_ticks(1);
        send_load(10, 5, 40, 12, 0, 20, 16'hFFFF);
        send_ticks(16);
        send_load(-2048, -2048, 2047, 2047, -2048, 2047, 16'h0000);
        send_ticks(3);
        send_load(50, 100, 80, 100, 60, 100, 16'h1234);
        send_ticks(1);
        send_load(0, -20, 100, -5, 30, 10, 16'hA5A5);
        send_ticks(2);
        send_load(5, 230, 200, 300, 90, 260, 16'h5A5A);
        send_ticks(2);
        send_load(0, 0, 0, 1, 0, 0, 16'h8001);
        send_ticks(1);
    endtask

    task automatic rand_triangle(input bit wide);
        int base, y [3], x [3], h;
        if (wide) begin
            for (int i = 0; i < 3; i++) begin
                x[i] = $urandom_range(0, 4095) - 2048;
                y[i] = $urandom_range(0, 4095) - 2048;
            end
        end else begin
            base = $urandom_range(0, 300) - 40;
            h = ($urandom_range(0, 7) == 0) ? 120 : 30;
            for (int i = 0; i < 3; i++) begin
                x[i] = $urandom_range(0, 400) - 80;
                y[i] = base + $urandom_range(0, h);
            end
        end
        send_load(x[0], y[0], x[1], y[1], x[2], y[2], 16'($urandom));
        h = last_row - cur_row;
        case ($urandom_range(0, 9))
            0:       send_ticks($urandom_range(0, h));
            1:       send_ticks(h + $urandom_range(1, 3));
            default: send_ticks(h);
        endcase
    endtask

    task automatic test_random(input int quota);
        int stop;
        t_in_word w;
        logic [95:0] rnd;
        stop = sent + quota;
        while (sent < stop) begin
            if ($urandom_range(0, 9) == 0) begin
                rnd = {$urandom, $urandom, $urandom};
                w = rnd[$bits(t_in_word)-1:0];
                if (w.kind == K_LOAD) begin
                    w.vy0 = 12'($urandom_range(0, 60));
                    w.vy1 = 12'($urandom_range(0, 60));
                    w.vy2 = 12'($urandom_range(0, 60));
                end
                send_word(w);
            end else begin
                rand_triangle($urandom_range(0, 29) == 0);
            end
        end
    endtask

    task automatic test_full_range();
        repeat (2) rand_triangle(1'b1);
    endtask

    task automatic test_no_idle();
        no_idle = 1'b1;
        test_random(150);
        no_idle = 1'b0;
    endtask

    initial begin
        errors = 0;
        sent = 0;
        cycles = 0;
        no_idle = 1'b0;
        cur_row = 0;
        last_row = 0;
        left_short = 1'b0;
        color_q = '0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_range();
        test_random(400);
        test_no_idle();
        in_ch.valid <= 1'b0;
        while (span_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end
endmodule

### sim.f
hw/rtl/tsr_pkg.sv
hw/rtl/tsr_if.sv
hw/rtl/tsr_bound_mem.sv
hw/rtl/triangle_span_rasterizer.sv
tb/sv/testbench.sv
